@@ sv/nec_ir_frame_decoder_core_macros.svh @@
// Assertion macros shared by the decoder RTL.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef NEC_IR_FRAME_DECODER_CORE_MACROS_SVH
`define NEC_IR_FRAME_DECODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition on the same edge as its trigger.
`define NEC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition on the edge after its trigger.
`define NEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define NEC_ASSERT_SAME(label, ante, cons, msg)
`define NEC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ sv/necdec_pkg.sv @@
package necdec_pkg;

	// Frame geometry
	localparam int DATA_BITS = 32;
	localparam int DUR_W     = 16;
	localparam int IDX_W     = 7;
	localparam int CODE_W    = 32;
	localparam int BITCNT_W  = 6;
	localparam int OUT_TDATA_W = ((CODE_W + BITCNT_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	// Entry indexes within one capture
	localparam logic [IDX_W-1:0] IDX_HDR_MARK    = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_HDR_SPACE   = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_FIRST_DATA  = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_LAST_DATA   = IDX_W'(2 + 2 * DATA_BITS);
	localparam logic [IDX_W-1:0] IDX_REPEAT_LAST = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_FRAME_MIN   = IDX_W'(2 * DATA_BITS + 3);
	localparam logic [IDX_W-1:0] IDX_MAX         = IDX_W'(127);

	localparam logic [CODE_W-1:0]   REPEAT_CODE    = '1;
	localparam logic [BITCNT_W-1:0] FRAME_BIT_COUNT = BITCNT_W'(DATA_BITS);

	// Timing in microseconds
	localparam int EXCESS_US     = 100;
	localparam int HDR_MARK_US   = 9000;
	localparam int HDR_SPACE_US  = 4500;
	localparam int BIT_MARK_US   = 560;
	localparam int ONE_SPACE_US  = 1690;
	localparam int ZERO_SPACE_US = 560;
	localparam int RPT_SPACE_US  = 2250;
	localparam int WIN_LO_DIV    = 67;
	localparam int WIN_HI_DIV    = 40;

	// Acceptance windows in ticks: [t/67, t/40 + 1]
	localparam logic [DUR_W-1:0] HDR_MARK_LO =
		DUR_W'((HDR_MARK_US + EXCESS_US) / WIN_LO_DIV);
	localparam logic [DUR_W-1:0] HDR_MARK_HI =
		DUR_W'((HDR_MARK_US + EXCESS_US) / WIN_HI_DIV + 1);
	localparam logic [DUR_W-1:0] BIT_MARK_LO =
		DUR_W'((BIT_MARK_US + EXCESS_US) / WIN_LO_DIV);
	localparam logic [DUR_W-1:0] BIT_MARK_HI =
		DUR_W'((BIT_MARK_US + EXCESS_US) / WIN_HI_DIV + 1);
	localparam logic [DUR_W-1:0] HDR_SPACE_LO =
		DUR_W'((HDR_SPACE_US - EXCESS_US) / WIN_LO_DIV);
	localparam logic [DUR_W-1:0] HDR_SPACE_HI =
		DUR_W'((HDR_SPACE_US - EXCESS_US) / WIN_HI_DIV + 1);
	localparam logic [DUR_W-1:0] RPT_SPACE_LO =
		DUR_W'((RPT_SPACE_US - EXCESS_US) / WIN_LO_DIV);
	localparam logic [DUR_W-1:0] RPT_SPACE_HI =
		DUR_W'((RPT_SPACE_US - EXCESS_US) / WIN_HI_DIV + 1);
	localparam logic [DUR_W-1:0] ONE_SPACE_LO =
		DUR_W'((ONE_SPACE_US - EXCESS_US) / WIN_LO_DIV);
	localparam logic [DUR_W-1:0] ONE_SPACE_HI =
		DUR_W'((ONE_SPACE_US - EXCESS_US) / WIN_HI_DIV + 1);
	localparam logic [DUR_W-1:0] ZERO_SPACE_LO =
		DUR_W'((ZERO_SPACE_US - EXCESS_US) / WIN_LO_DIV);
	localparam logic [DUR_W-1:0] ZERO_SPACE_HI =
		DUR_W'((ZERO_SPACE_US - EXCESS_US) / WIN_HI_DIV + 1);

	typedef logic [DUR_W-1:0] dur_t;

	// Window matches for one pulse
	typedef struct packed {
		logic hdr_mark;
		logic hdr_space;
		logic rpt_space;
		logic bit_mark;
		logic one_space;
		logic zero_space;
	} pulse_checks_t;

endpackage

@@ sv/necdec_pulse_check.sv @@
module necdec_pulse_check (
	input  necdec_pkg::dur_t          duration,
	output necdec_pkg::pulse_checks_t checks
);

	// Compare the duration against every constant window
	always_comb begin
		checks.hdr_mark   = (duration >= necdec_pkg::HDR_MARK_LO) &&
			(duration <= necdec_pkg::HDR_MARK_HI);
		checks.hdr_space  = (duration >= necdec_pkg::HDR_SPACE_LO) &&
			(duration <= necdec_pkg::HDR_SPACE_HI);
		checks.rpt_space  = (duration >= necdec_pkg::RPT_SPACE_LO) &&
			(duration <= necdec_pkg::RPT_SPACE_HI);
		checks.bit_mark   = (duration >= necdec_pkg::BIT_MARK_LO) &&
			(duration <= necdec_pkg::BIT_MARK_HI);
		checks.one_space  = (duration >= necdec_pkg::ONE_SPACE_LO) &&
			(duration <= necdec_pkg::ONE_SPACE_HI);
		checks.zero_space = (duration >= necdec_pkg::ZERO_SPACE_LO) &&
			(duration <= necdec_pkg::ZERO_SPACE_HI);
	end

endmodule

@@ sv/nec_ir_frame_decoder_core.sv @@
// Channel  Dir  tdata (low bit up)                 tuser / tlast
// s_*      in   duration_ticks[15:0]               tlast = last_entry
// m_*      out  code[31:0], bit_count[37:32], pad  tuser = decoded[0], is_repeat[1]
//
// One pulse is taken per cycle unless a last entry waits on a stalled result; the
// last entry passes the input register and then the result register. The window
// compares and the state update sit between those two registers.
// arst_n clears the capture state and both valid flags.
// A stalled result holds only a last entry in the input register; other entries
// keep flowing.
`include "nec_ir_frame_decoder_core_macros.svh"

module nec_ir_frame_decoder_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [necdec_pkg::DUR_W-1:0]         s_tdata,   // duration_ticks
	input  logic                                 s_tlast,   // last_entry
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [necdec_pkg::OUT_TDATA_W-1:0]   m_tdata,   // code, bit_count, zero pad
	output logic [necdec_pkg::OUT_TUSER_W-1:0]   m_tuser    // decoded, is_repeat
);

	// Input register
	logic                       valid_s1;
	necdec_pkg::dur_t           dur_s1;
	logic                       last_s1;

	// Capture state
	logic [necdec_pkg::IDX_W-1:0]     entry_idx_q;
	logic [necdec_pkg::DATA_BITS-1:0] shift_q;
	logic                             fail_q;
	logic                             rpt_ok_q;

	// Result register
	logic                                 out_valid_q;
	logic [necdec_pkg::OUT_TDATA_W-1:0]   out_data_q;
	logic [necdec_pkg::OUT_TUSER_W-1:0]   out_user_q;

	necdec_pkg::pulse_checks_t        checks;
	logic                             fire_s1;
	logic                             emit;
	logic [necdec_pkg::DATA_BITS-1:0] shift_nxt;
	logic                             fail_nxt;
	logic                             rpt_ok_nxt;
	logic                             res_decoded;
	logic                             res_repeat;
	logic [necdec_pkg::CODE_W-1:0]    res_code;
	logic [necdec_pkg::BITCNT_W-1:0]  res_bits;

	necdec_pulse_check u_check (
		.duration (dur_s1),
		.checks   (checks)
	);

	// Advance unless a last entry waits for a full result register
	assign fire_s1  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign emit     = fire_s1 && last_s1;
	assign s_tready = !valid_s1 || fire_s1;

	// Hold the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			dur_s1  <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Update the capture state for the entry at the current index
	always_comb begin
		shift_nxt  = shift_q;
		fail_nxt   = fail_q;
		rpt_ok_nxt = rpt_ok_q;
		if (entry_idx_q == necdec_pkg::IDX_HDR_MARK) begin
			rpt_ok_nxt = checks.hdr_mark;
			if (!checks.hdr_mark) begin
				fail_nxt = 1'b1;
			end
		end else if (entry_idx_q == necdec_pkg::IDX_HDR_SPACE) begin
			if (!checks.rpt_space) begin
				rpt_ok_nxt = 1'b0;
			end
			if (!checks.hdr_space) begin
				fail_nxt = 1'b1;
			end
		end else if (entry_idx_q >= necdec_pkg::IDX_FIRST_DATA &&
				entry_idx_q <= necdec_pkg::IDX_LAST_DATA) begin
			if (entry_idx_q[0]) begin
				// mark of a data bit
				if (!checks.bit_mark) begin
					fail_nxt = 1'b1;
					if (entry_idx_q == necdec_pkg::IDX_FIRST_DATA) begin
						rpt_ok_nxt = 1'b0;
					end
				end
			end else if (checks.one_space) begin
				shift_nxt = {shift_q[necdec_pkg::DATA_BITS-2:0], 1'b1};
			end else if (checks.zero_space) begin
				shift_nxt = {shift_q[necdec_pkg::DATA_BITS-2:0], 1'b0};
			end else begin
				fail_nxt = 1'b1;
			end
		end
	end

	// Build the result of a finished capture
	always_comb begin
		res_decoded = 1'b0;
		res_repeat  = 1'b0;
		res_code    = '0;
		res_bits    = '0;
		if (entry_idx_q == necdec_pkg::IDX_REPEAT_LAST && rpt_ok_nxt) begin
			res_decoded = 1'b1;
			res_repeat  = 1'b1;
			res_code    = necdec_pkg::REPEAT_CODE;
		end else if (entry_idx_q >= necdec_pkg::IDX_FRAME_MIN && !fail_nxt) begin
			res_decoded = 1'b1;
			res_code    = necdec_pkg::CODE_W'(shift_nxt);
			res_bits    = necdec_pkg::FRAME_BIT_COUNT;
		end
	end

	// Advance the capture state; drop it after the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_idx_q <= '0;
			shift_q     <= '0;
			fail_q      <= 1'b0;
			rpt_ok_q    <= 1'b0;
		end else if (fire_s1) begin
			if (last_s1) begin
				entry_idx_q <= '0;
				shift_q     <= '0;
				fail_q      <= 1'b0;
				rpt_ok_q    <= 1'b0;
			end else begin
				if (entry_idx_q != necdec_pkg::IDX_MAX) begin
					entry_idx_q <= entry_idx_q + 1'b1;
				end
				shift_q  <= shift_nxt;
				fail_q   <= fail_nxt;
				rpt_ok_q <= rpt_ok_nxt;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= necdec_pkg::OUT_TDATA_W'({res_bits, res_code});
			out_user_q <= {res_repeat, res_decoded};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// A failure result carries no code and no repeat flag
	`NEC_ASSERT_SAME(a_fail_is_zero, m_tvalid && !m_tuser[0], m_tdata == '0 && !m_tuser[1], "failure result not cleared")
	// A repeat result carries all ones and no bit count
	`NEC_ASSERT_SAME(a_repeat_form, m_tvalid && m_tuser[1], m_tuser[0] && m_tdata[necdec_pkg::CODE_W-1:0] == necdec_pkg::REPEAT_CODE && m_tdata[necdec_pkg::CODE_W+necdec_pkg::BITCNT_W-1:necdec_pkg::CODE_W] == '0, "malformed repeat result")
	// The capture restarts after every last entry
	`NEC_ASSERT_NEXT(a_restart, emit, entry_idx_q == '0 && !fail_q && !rpt_ok_q, "capture state not cleared")
	// A result is presented right after a last entry is taken
	`NEC_ASSERT_NEXT(a_emit_valid, emit, m_tvalid, "result lost")

endmodule
